// ----- hdl/bktt_pkg.sv -----
// bktt_pkg: types and constants of the bucketed key table
// field widths, command and status codes, slot entry layout
// no dependencies
package bktt_pkg;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned BKT_IN_W = 3;
  localparam int unsigned KEY_W    = 30;
  localparam int unsigned PL_W     = 32;
  localparam int unsigned STAT_W   = 2;
  localparam int unsigned IDX_W    = 4;

  // number of distinct bucket codes on the input field
  localparam int unsigned BKT_IN_N = 1 << BKT_IN_W;

  localparam int unsigned IN_DATA_W  = 72;  // 67 bits of fields, zero filled
  localparam int unsigned OUT_DATA_W = 40;  // 38 bits of fields, zero filled

  // command codes
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] ST_PRESENT   = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd3;

  // one slot of the table as stored in memory
  typedef struct packed {
    logic             deleted;
    logic [PL_W-1:0]  data;
    logic [KEY_W-1:0] key;
  } slot_t;

  localparam int unsigned SLOT_ENTRY_W = $bits(slot_t);

  // sequencer states
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_FILL = 5'b00010,
    S_SCAN = 5'b00100,
    S_WB   = 5'b01000,
    S_RESP = 5'b10000
  } state_e;

endpackage

// ----- hdl/bucketed_key_table_with_tombstones_unit.sv -----
// bucketed_key_table_with_tombstones_unit: keyed table split into buckets
// search, insert and delete with tombstones, one slot compared per cycle
// depends on bktt_pkg and bktt_ram
//
// usage
//   s_axis carries one command item: cmd, bucket, key, payload. m_axis returns
//   exactly one result item per command: status, found_payload, slot_index.
//   the bucket field is taken modulo NUM_BUCKETS through a small constant table
//   timing
//   an accepted item reads the bucket fill count, then scans the
//   bucket's used slots through the slot memory read port, one slot per cycle,
//   then waits for the last read (fewer reads on an early key hit). a write
//   back state and a response state follow. a new item is taken only after
//   the last one has left the response state; the single slot memory read
//   port sets the scan rate
//   s_axis_tready is high only while the sequencer is idle
//   stalls
//   the result sits in an output register; a new item is accepted while an
//   earlier result still waits, and a finished result waits in the response
//   state until the output register is free
//   reset
//   fill counts read as zero through per bucket valid bits, so the table is
//   empty right after reset; no clearing pass. slot memory needs no reset,
//   only slots below the fill count are ever read and those were written
module bucketed_key_table_with_tombstones_unit
  import bktt_pkg::*;
#(
  parameter int unsigned NUM_BUCKETS      = 8,
  parameter int unsigned SLOTS_PER_BUCKET = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // command items
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [1:0] cmd, [4:2] bucket, [34:5] key, [66:35] payload, [71:67] zero
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // result items
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [1:0] status, [33:2] found_payload, [37:34] slot_index, [39:38] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  localparam int unsigned BKT_W  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int unsigned SLOT_W = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
  localparam int unsigned FILL_W = $clog2(SLOTS_PER_BUCKET + 1);
  localparam int unsigned TOTAL  = NUM_BUCKETS * SLOTS_PER_BUCKET;
  localparam int unsigned ADDR_W = (TOTAL > 1) ? $clog2(TOTAL) : 1;
  localparam logic [ADDR_W-1:0] SLOTS_A = ADDR_W'(SLOTS_PER_BUCKET);
  localparam logic [FILL_W-1:0] SLOTS_F = FILL_W'(SLOTS_PER_BUCKET);

  // input fields
  logic [CMD_W-1:0]    in_cmd;
  logic [BKT_IN_W-1:0] in_bucket;
  logic [KEY_W-1:0]    in_key;
  logic [PL_W-1:0]     in_payload;

  assign in_cmd     = s_axis_tdata[1:0];
  assign in_bucket  = s_axis_tdata[4:2];
  assign in_key     = s_axis_tdata[34:5];
  assign in_payload = s_axis_tdata[66:35];

  // bucket code modulo bucket count, one constant entry per code
  logic [BKT_W-1:0] bmod_tab [BKT_IN_N];
  for (genvar g = 0; g < BKT_IN_N; g++) begin : g_bmod
    assign bmod_tab[g] = BKT_W'(g % NUM_BUCKETS);
  end

  logic [BKT_W-1:0] in_bmod;
  assign in_bmod = bmod_tab[in_bucket];

  state_e state_q, state_d;

  // item registers
  logic [CMD_W-1:0]  cmd_q;
  logic [BKT_W-1:0]  bkt_q;
  logic [KEY_W-1:0]  key_q;
  logic [PL_W-1:0]   pl_q;
  logic [ADDR_W-1:0] base_q;
  logic [FILL_W-1:0] fill_q;

  // scan state
  logic [FILL_W-1:0] rd_idx_q;
  logic              pend_q;
  logic [SLOT_W-1:0] pend_idx_q;
  logic              match_q;
  logic [SLOT_W-1:0] match_idx_q;
  logic [PL_W-1:0]   match_data_q;
  logic              tomb_q;
  logic [SLOT_W-1:0] tomb_idx_q;

  // finished result
  logic [STAT_W-1:0] res_status_q;
  logic [PL_W-1:0]   res_payload_q;
  logic [IDX_W-1:0]  res_idx_q;

  // output register
  logic              out_valid_q;
  logic [STAT_W-1:0] out_status_q;
  logic [PL_W-1:0]   out_payload_q;
  logic [IDX_W-1:0]  out_idx_q;
  logic              out_load;

  // fill count valid bits, cleared by reset
  logic [NUM_BUCKETS-1:0] bkt_vld_q;

  // memories
  logic              fill_we;
  logic [FILL_W-1:0] fill_rdata;
  logic              slot_we;
  logic [ADDR_W-1:0] slot_waddr;
  logic [ADDR_W-1:0] slot_raddr;
  slot_t             slot_wdata;
  slot_t             slot_rdata;

  logic              in_acc;
  logic              hit_now;
  logic              tomb_now;
  logic              issue;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // live slot with the wanted key, or first tombstone, in the slot just read
  assign hit_now  = (state_q == S_SCAN) && pend_q && !slot_rdata.deleted
                    && (slot_rdata.key == key_q);
  assign tomb_now = (state_q == S_SCAN) && pend_q && slot_rdata.deleted && !tomb_q;
  assign issue    = (state_q == S_SCAN) && (rd_idx_q != fill_q);

  assign slot_raddr = base_q + ADDR_W'(rd_idx_q);

  // finished result moves into the output register when that is free
  assign out_load = (state_q == S_RESP) && (!out_valid_q || m_axis_tready);

  // decision of the write back cycle
  logic [STAT_W-1:0] dec_status;
  logic [PL_W-1:0]   dec_payload;
  logic [SLOT_W-1:0] dec_idx;
  logic              dec_we;
  logic              dec_append;
  logic              dec_del;

  always_comb begin
    dec_status  = ST_NOT_FOUND;
    dec_payload = '0;
    dec_idx     = '0;
    dec_we      = 1'b0;
    dec_append  = 1'b0;
    dec_del     = 1'b0;
    case (cmd_q)
      CMD_SEARCH: begin
        if (match_q) begin
          dec_status  = ST_DONE;
          dec_payload = match_data_q;
          dec_idx     = match_idx_q;
        end
      end
      CMD_INSERT: begin
        if (match_q) begin
          dec_status = ST_PRESENT;
          dec_idx    = match_idx_q;
        end else if (tomb_q) begin
          dec_status = ST_DONE;
          dec_idx    = tomb_idx_q;
          dec_we     = 1'b1;
        end else if (fill_q < SLOTS_F) begin
          dec_status = ST_DONE;
          dec_idx    = fill_q[SLOT_W-1:0];
          dec_we     = 1'b1;
          dec_append = 1'b1;
        end else begin
          dec_status = ST_FULL;
        end
      end
      CMD_DELETE: begin
        if (match_q) begin
          dec_status = ST_DONE;
          dec_idx    = match_idx_q;
          dec_we     = 1'b1;
          dec_del    = 1'b1;
        end
      end
      default: begin
        dec_status = ST_NOT_FOUND;
      end
    endcase
  end

  // slot index masked to the output width
  logic [SLOT_W+IDX_W-1:0] dec_idx_ext;
  assign dec_idx_ext = {{IDX_W{1'b0}}, dec_idx};

  assign slot_we    = (state_q == S_WB) && dec_we;
  assign slot_waddr = base_q + ADDR_W'(dec_idx);
  assign slot_wdata = '{deleted: dec_del,
                        data:    dec_del ? match_data_q : pl_q,
                        key:     key_q};

  assign fill_we = (state_q == S_WB) && dec_append;

  bktt_ram #(
    .WIDTH (FILL_W),
    .DEPTH (NUM_BUCKETS)
  ) u_fill_ram (
    .clk_i   (clk_i),
    .we_i    (fill_we),
    .waddr_i (bkt_q),
    .wdata_i (fill_q + FILL_W'(1)),
    .raddr_i (in_bmod),
    .rdata_o (fill_rdata)
  );

  bktt_ram #(
    .WIDTH (SLOT_ENTRY_W),
    .DEPTH (TOTAL)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wdata),
    .raddr_i (slot_raddr),
    .rdata_o (slot_rdata)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_FILL;
        end
      end
      S_FILL: state_d = S_SCAN;
      S_SCAN: begin
        // stop on the first live hit, or when the last used slot was checked
        if (hit_now || (rd_idx_q == fill_q)) begin
          state_d = S_WB;
        end
      end
      S_WB: state_d = S_RESP;
      S_RESP: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      bkt_vld_q   <= '0;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
      match_q     <= 1'b0;
      tomb_q      <= 1'b0;
      rd_idx_q    <= '0;
    end else begin
      state_q <= state_d;
      if (fill_we) begin
        bkt_vld_q[bkt_q] <= 1'b1;
      end
      // new result loaded, or an unread one kept
      out_valid_q <= out_load || (out_valid_q && !m_axis_tready);
      case (state_q)
        S_FILL: begin
          rd_idx_q <= '0;
          pend_q   <= 1'b0;
          match_q  <= 1'b0;
          tomb_q   <= 1'b0;
        end
        S_SCAN: begin
          pend_q <= issue;
          if (issue) begin
            rd_idx_q <= rd_idx_q + FILL_W'(1);
          end
          if (hit_now) begin
            match_q <= 1'b1;
          end
          if (tomb_now) begin
            tomb_q <= 1'b1;
          end
        end
        default: begin
          pend_q <= 1'b0;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q  <= in_cmd;
      bkt_q  <= in_bmod;
      key_q  <= in_key;
      pl_q   <= in_payload;
      base_q <= ADDR_W'(in_bmod) * SLOTS_A;
    end
    if (state_q == S_FILL) begin
      fill_q <= bkt_vld_q[bkt_q] ? fill_rdata : '0;
    end
    if (issue) begin
      pend_idx_q <= rd_idx_q[SLOT_W-1:0];
    end
    if (hit_now) begin
      match_idx_q  <= pend_idx_q;
      match_data_q <= slot_rdata.data;
    end
    if (tomb_now) begin
      tomb_idx_q <= pend_idx_q;
    end
    if (state_q == S_WB) begin
      res_status_q  <= dec_status;
      res_payload_q <= dec_payload;
      res_idx_q     <= dec_idx_ext[IDX_W-1:0];
    end
    if (out_load) begin
      out_status_q  <= res_status_q;
      out_payload_q <= res_payload_q;
      out_idx_q     <= res_idx_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_DATA_W - STAT_W - PL_W - IDX_W){1'b0}},
                          out_idx_q, out_payload_q, out_status_q};

  // an append only happens while the bucket still has room
  a_append_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_we |-> (fill_q < SLOTS_F))
    else $error("append into a full bucket");

  // a found slot lies below the fill count of its bucket
  a_match_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_WB) && match_q) |-> (FILL_W'(match_idx_q) < fill_q))
    else $error("matched slot beyond fill count");

  // a reused tombstone lies below the fill count of its bucket
  a_tomb_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_WB) && tomb_q) |-> (FILL_W'(tomb_idx_q) < fill_q))
    else $error("tombstone beyond fill count");

  // a result only enters the output register from the response state
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_RESP))
    else $error("result without a response cycle");

endmodule

// ----- hdl/bktt_ram.sv -----
// bktt_ram: generic simple dual port ram, one write and one read port
// read data registered, no reset on the array
// no dependencies
module bktt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// testbench: self-checking bench for bucketed_key_table_with_tombstones_unit
// drives command items, predicts results with its own table or typed values, checks every result
// depends on bktt_pkg and the unit under test
module testbench;
  import bktt_pkg::*;

  localparam int unsigned NB           = 8;
  localparam int unsigned SPB          = 16;
  localparam int unsigned ITEMS        = 550;
  localparam int unsigned QUIET_LIMIT  = 4000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned CALM_TAIL    = 80;
  localparam int unsigned BURST_EVERY  = 120;
  localparam int unsigned POOL_SPAN    = 24;

  // code the block does not use, must change nothing
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam logic [KEY_W-1:0]    KEY_TOP = 30'd999999998;
  localparam logic [KEY_W-1:0]    KEY_ALL = '1;
  localparam logic [PL_W-1:0]     PL_ALL  = '1;
  localparam logic [BKT_IN_W-1:0] BKT_TOP = '1;

  typedef logic [CMD_W-1:0]    cmd_t;
  typedef logic [BKT_IN_W-1:0] bkt_t;
  typedef logic [KEY_W-1:0]    key_t;
  typedef logic [PL_W-1:0]     word_t;

  // laid out as on m_axis_tdata, status in the low bits
  typedef struct packed {
    logic [IDX_W-1:0]  slot;
    logic [PL_W-1:0]   payload;
    logic [STAT_W-1:0] status;
  } result_t;

  typedef struct {
    cmd_t    cmd;
    bkt_t    bkt;
    key_t    key;
    word_t   pl;
    bit      typed;
    result_t want;
  } dir_row_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  // own copy of the table
  key_t        tbl_key  [NB*SPB];
  word_t       tbl_data [NB*SPB];
  bit          tbl_tomb [NB*SPB];
  int unsigned tbl_fill [NB];

  result_t     results_due[$];
  key_t        pool_base [NB];
  bit          idle_on = 1'b1;
  int unsigned items_sent;
  int unsigned results_checked;
  int unsigned mismatches;
  int unsigned quiet_cycles;
  int unsigned status_seen [4];

  // directed part: expected result typed in where it is obvious, else predicted
  dir_row_t dir_rows [20] = '{
    // empty table, every miss and the unused code
    '{CMD_SEARCH, 3'd0, '0, '0, 1'b1, '{4'd0, 32'd0, ST_NOT_FOUND}},
    '{CMD_DELETE, BKT_TOP, KEY_ALL, PL_ALL, 1'b1, '{4'd0, 32'd0, ST_NOT_FOUND}},
    '{CMD_UNUSED, 3'd0, '0, '0, 1'b1, '{4'd0, 32'd0, ST_NOT_FOUND}},
    // first insert, then the same key again
    '{CMD_INSERT, 3'd0, '0, '0, 1'b1, '{4'd0, 32'd0, ST_DONE}},
    '{CMD_INSERT, 3'd0, '0, PL_ALL, 1'b1, '{4'd0, 32'd0, ST_PRESENT}},
    '{CMD_SEARCH, 3'd0, '0, PL_ALL, 1'b1, '{4'd0, 32'd0, ST_DONE}},
    // top bucket with key 999999998 and the all ones key
    '{CMD_INSERT, BKT_TOP, KEY_TOP, PL_ALL, 1'b1, '{4'd0, 32'd0, ST_DONE}},
    '{CMD_INSERT, BKT_TOP, KEY_ALL, 32'hA5A5A5A5, 1'b1, '{4'd1, 32'd0, ST_DONE}},
    '{CMD_SEARCH, BKT_TOP, KEY_TOP, '0, 1'b1, '{4'd0, PL_ALL, ST_DONE}},
    '{CMD_SEARCH, 3'd0, KEY_TOP, '0, 1'b1, '{4'd0, 32'd0, ST_NOT_FOUND}},
    // delete leaves a tombstone that never matches
    '{CMD_DELETE, BKT_TOP, KEY_TOP, '0, 1'b1, '{4'd0, 32'd0, ST_DONE}},
    '{CMD_SEARCH, BKT_TOP, KEY_TOP, '0, 1'b1, '{4'd0, 32'd0, ST_NOT_FOUND}},
    '{CMD_DELETE, BKT_TOP, KEY_TOP, '0, 1'b1, '{4'd0, 32'd0, ST_NOT_FOUND}},
    // a new key takes the tombstone slot
    '{CMD_INSERT, BKT_TOP, 30'd12345, 32'h5A5A5A5A, 1'b1, '{4'd0, 32'd0, ST_DONE}},
    '{CMD_SEARCH, BKT_TOP, KEY_ALL, '0, 1'b0, '0},
    '{CMD_INSERT, BKT_TOP, KEY_ALL, '0, 1'b0, '0},
    '{CMD_DELETE, BKT_TOP, 30'd12345, '0, 1'b0, '0},
    '{CMD_INSERT, BKT_TOP, KEY_TOP, 32'h0F0F0F0F, 1'b0, '0},
    '{CMD_SEARCH, BKT_TOP, KEY_TOP, '0, 1'b0, '0},
    '{CMD_UNUSED, BKT_TOP, KEY_ALL, PL_ALL, 1'b1, '{4'd0, 32'd0, ST_NOT_FOUND}}
  };

  bucketed_key_table_with_tombstones_unit #(
    .NUM_BUCKETS      (NB),
    .SLOTS_PER_BUCKET (SPB)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // apply one command to the local table and return the result it gives
  function automatic result_t table_op(cmd_t cmd, bkt_t bkt_in, key_t key, word_t pl);
    int unsigned b;
    int unsigned base;
    int unsigned pos;
    int          hit;
    int          tomb;
    result_t     r;
    b    = bkt_in % NB;
    base = b * SPB;
    r    = '{slot: '0, payload: '0, status: ST_NOT_FOUND};
    hit  = -1;
    tomb = -1;
    // first live match and first tombstone among the used slots
    for (int i = 0; i < int'(tbl_fill[b]); i++) begin
      if (tbl_tomb[base+i]) begin
        if (tomb < 0) tomb = i;
      end else if (hit < 0 && tbl_key[base+i] == key) begin
        hit = i;
      end
    end
    case (cmd)
      CMD_SEARCH: begin
        if (hit >= 0) begin
          r.status  = ST_DONE;
          r.payload = tbl_data[base+hit];
          r.slot    = IDX_W'(hit);
        end
      end
      CMD_INSERT: begin
        if (hit >= 0) begin
          r.status = ST_PRESENT;
          r.slot   = IDX_W'(hit);
        end else if (tomb >= 0 || tbl_fill[b] < SPB) begin
          if (tomb >= 0) begin
            pos = tomb;
          end else begin
            pos = tbl_fill[b];
            tbl_fill[b]++;
          end
          tbl_key[base+pos]  = key;
          tbl_data[base+pos] = pl;
          tbl_tomb[base+pos] = 1'b0;
          r.status = ST_DONE;
          r.slot   = IDX_W'(pos);
        end else begin
          r.status = ST_FULL;
        end
      end
      CMD_DELETE: begin
        if (hit >= 0) begin
          tbl_tomb[base+hit] = 1'b1;
          r.status = ST_DONE;
          r.slot   = IDX_W'(hit);
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // offer one command item, hold it until taken, then record what it should give
  task automatic send_op(cmd_t cmd, bkt_t bkt, key_t key, word_t pl, bit typed,
                         result_t want);
    result_t model;
    int unsigned gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, pl, key, bkt, cmd};
    do @(posedge clk_i); while (!s_axis_tready);
    model = table_op(cmd, bkt, key, pl);
    results_due.push_back(typed ? want : model);
    status_seen[model.status]++;
    items_sent++;
  endtask

  // sender holds off until every outstanding result has come back
  task automatic wait_for_drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (results_due.size() != 0);
  endtask

  // result side: random stall bursts, none near the end
  initial begin : sink_pacing
    int unsigned n;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 5);
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  // result check against the oldest expectation, plus the no-progress watchdog
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = result_t'(m_axis_tdata[$bits(result_t)-1:0]);
        if (results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result at %0t: status %0d payload %h slot %0d",
                     $time, got.status, got.payload, got.slot);
        end else begin
          want = results_due.pop_front();
          results_checked++;
          if (got != want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch at %0t: expected status %0d payload %h slot %0d, got status %0d payload %h slot %0d",
                       $time, want.status, want.payload, want.slot,
                       got.status, got.payload, got.slot);
          end
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("no item moved for %0d cycles", QUIET_LIMIT);
          $display("TB_ERROR");
          $finish;
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned r;
    int unsigned since_burst;
    bit          paused;
    bkt_t        b;
    cmd_t        c;
    key_t        k;
    since_burst = 0;
    paused      = 1'b0;
    // each bucket gets a narrow key range so that keys repeat and buckets fill
    foreach (pool_base[i]) pool_base[i] = key_t'($urandom_range(0, 999999900));
    pool_base[NB-1] = KEY_ALL - key_t'(POOL_SPAN);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i])
      send_op(dir_rows[i].cmd, dir_rows[i].bkt, dir_rows[i].key, dir_rows[i].pl,
              dir_rows[i].typed, dir_rows[i].want);
    wait_for_drain();

    while (items_sent < ITEMS) begin
      if (items_sent + CALM_TAIL >= ITEMS) idle_on = 1'b0;
      if (!paused && items_sent >= ITEMS / 2) begin
        paused = 1'b1;
        wait_for_drain();
      end
      if (since_burst == 0) begin
        // fill one bucket with fresh keys until it overflows
        b = bkt_t'($urandom_range(0, NB - 1));
        repeat (SPB + 3) send_op(CMD_INSERT, b, key_t'($urandom), $urandom, 1'b0, '0);
        since_burst = BURST_EVERY;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          // noise: any code, any bucket, any 30 bit key
          send_op(cmd_t'($urandom_range(0, 3)), bkt_t'($urandom), key_t'($urandom),
                  $urandom, 1'b0, '0);
        end else begin
          // mostly two busy buckets, keys drawn from the bucket's own range
          if ($urandom_range(0, 2) != 0)
            b = ($urandom_range(0, 1) == 0) ? bkt_t'(2) : bkt_t'(NB - 1);
          else
            b = bkt_t'($urandom_range(0, NB - 1));
          k = pool_base[b] + key_t'($urandom_range(0, POOL_SPAN - 1));
          c = (r < 45) ? CMD_INSERT : (r < 72) ? CMD_SEARCH :
              (r < 95) ? CMD_DELETE : CMD_UNUSED;
          send_op(c, b, k, $urandom, 1'b0, '0);
        end
        since_burst--;
      end
    end
    s_axis_tvalid <= 1'b0;

    while (results_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d items, %0d results checked, %0d mismatches", items_sent,
             results_checked, mismatches);
    $display("outcomes: %0d done, %0d not found, %0d already present, %0d bucket full",
             status_seen[ST_DONE], status_seen[ST_NOT_FOUND], status_seen[ST_PRESENT],
             status_seen[ST_FULL]);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
